@@ hw/rtl/source_slot_table_failover_arbiter_macros.svh @@
// assertion macros for the source slot table failover arbiter
`ifndef SOURCE_SLOT_TABLE_FAILOVER_ARBITER_MACROS_SVH
`define SOURCE_SLOT_TABLE_FAILOVER_ARBITER_MACROS_SVH
`ifndef SYNTHESIS
`define SSFA_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ssfa: same-cycle check failed");
`define SSFA_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ssfa: next-cycle check failed");
`else
`define SSFA_ASSERT_IMP(label, clk, rst, ante, cons)
`define SSFA_ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

@@ hw/rtl/ssfa_pkg.sv @@
// shared types and constants of the source slot table failover arbiter
package ssfa_pkg;

  localparam int SLOTS      = 4;
  localparam int SLOT_W     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int OUT_SLOT_W = 2;
  localparam int ID_W       = 32;
  localparam int TIME_W     = 32;
  localparam int SIL_W      = 16;
  localparam int CFG_W      = 32;
  localparam int CFG_IDX_W  = 2;

  typedef logic [SLOT_W-1:0] slot_idx_t;

  localparam slot_idx_t LAST_SLOT = slot_idx_t'(SLOTS - 1);

  localparam logic [CFG_IDX_W-1:0] REG_PINNED_SOURCE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SILENT_TIME   = 2'd1;
  localparam logic [SIL_W-1:0]     SILENT_RESET      = 16'd1000;

  typedef struct packed {
    logic [ID_W-1:0]   source_id;
    logic [TIME_W-1:0] now_ms;
    logic              idle;
  } pkt_t;

  typedef struct packed {
    logic                  accepted;
    logic [OUT_SLOT_W-1:0] slot;
    logic                  new_entry;
    logic                  source_active;
    logic                  active_valid;
    logic [OUT_SLOT_W-1:0] active_slot;
    logic                  switched;
  } res_t;

  typedef struct packed {
    logic [ID_W-1:0]  pinned_source;
    logic [SIL_W-1:0] silent_time;
  } cfg_t;

  typedef struct packed {
    logic              en;
    logic              src_en;
    slot_idx_t         addr;
    logic [ID_W-1:0]   source;
    logic [TIME_W-1:0] last_heard;
    logic              idle;
  } tbl_wr_t;

  typedef struct packed {
    logic [ID_W-1:0]   source;
    logic [TIME_W-1:0] last_heard;
    logic              idle;
  } tbl_rd_t;

endpackage

@@ hw/rtl/ssfa_pkt_if.sv @@
// packet event channel
interface ssfa_pkt_if;
  import ssfa_pkg::*;
  logic valid;
  logic ready;
  pkt_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ hw/rtl/ssfa_res_if.sv @@
// arbitration result channel
interface ssfa_res_if;
  import ssfa_pkg::*;
  logic valid;
  logic ready;
  res_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ hw/rtl/ssfa_table.sv @@
// slot table memory: source id, last heard time and idle flag per slot
module ssfa_table (
  input  logic              clk,
  input  ssfa_pkg::tbl_wr_t wr,
  input  ssfa_pkg::slot_idx_t rd_addr,
  output ssfa_pkg::tbl_rd_t rd_data
);
  import ssfa_pkg::*;

  logic [ID_W-1:0]   src_mem  [SLOTS];
  logic [TIME_W-1:0] lh_mem   [SLOTS];
  logic              idle_mem [SLOTS];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      lh_mem[wr.addr]   <= wr.last_heard;
      idle_mem[wr.addr] <= wr.idle;
      if (wr.src_en) begin
        src_mem[wr.addr] <= wr.source;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_data.source     <= src_mem[rd_addr];
    rd_data.last_heard <= lh_mem[rd_addr];
    rd_data.idle       <= idle_mem[rd_addr];
  end

endmodule

@@ hw/rtl/ssfa_alu.sv @@
// shared subtract / less-than and equality unit
module ssfa_alu (
  input  logic [ssfa_pkg::TIME_W-1:0] sub_a,
  input  logic [ssfa_pkg::TIME_W-1:0] sub_b,
  input  logic [ssfa_pkg::ID_W-1:0]   eq_a,
  input  logic [ssfa_pkg::ID_W-1:0]   eq_b,
  output logic [ssfa_pkg::TIME_W-1:0] diff,
  output logic                        lt,
  output logic                        eq
);
  import ssfa_pkg::*;

  // borrow out of the unsigned subtract gives a < b
  assign {lt, diff} = {1'b0, sub_a} - {1'b0, sub_b};
  assign eq = (eq_a == eq_b);

endmodule

@@ hw/rtl/ssfa_ctrl.sv @@
// sequencer: slot scan, table update and takeover decision
module ssfa_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  ssfa_pkg::cfg_t        cfg,
  input  logic                  pkt_valid,
  output logic                  pkt_ready,
  input  ssfa_pkg::pkt_t        pkt_data,
  output logic                  res_valid,
  input  logic                  res_ready,
  output ssfa_pkg::res_t        res_data,
  output ssfa_pkg::tbl_wr_t     tbl_wr,
  output ssfa_pkg::slot_idx_t   tbl_rd_addr,
  input  ssfa_pkg::tbl_rd_t     tbl_rd
);
  import ssfa_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_SCAN = 5'b00010,
    ST_DIFF = 5'b00100,
    ST_CHK  = 5'b01000,
    ST_OUT  = 5'b10000
  } state_t;

  state_t state, state_next;

  // item registers
  logic [ID_W-1:0]   id_q;
  logic [TIME_W-1:0] now_q;
  logic              idle_q;

  // scan results
  slot_idx_t         scan_idx, scan_idx_next;
  logic              free_found, free_found_next;
  slot_idx_t         free_i, free_i_next;
  logic              old_found, old_found_next;
  slot_idx_t         old_i, old_i_next;
  logic [TIME_W-1:0] old_lh, old_lh_next;
  logic              pick_ok, pick_ok_next;
  slot_idx_t         pick, pick_next;
  logic              fresh, fresh_next;

  logic [TIME_W-1:0] diff_q, diff_q_next;
  logic              act_idle, act_idle_next;

  // arbiter state
  logic [SLOTS-1:0]  used, used_next;
  logic              have_active, have_active_next;
  slot_idx_t         cur, cur_next;

  res_t              res_q, res_next;

  // shared unit
  logic [TIME_W-1:0] sub_a, sub_b, alu_diff;
  logic [ID_W-1:0]   eq_a, eq_b;
  logic              alu_lt, alu_eq;

  logic              want_set, want_v, avail, changed;
  slot_idx_t         want_idx;

  ssfa_alu u_alu (
    .sub_a (sub_a),
    .sub_b (sub_b),
    .eq_a  (eq_a),
    .eq_b  (eq_b),
    .diff  (alu_diff),
    .lt    (alu_lt),
    .eq    (alu_eq)
  );

  assign pkt_ready = (state == ST_IDLE);
  assign res_valid = (state == ST_OUT);
  assign res_data  = res_q;

  always_comb begin
    sub_a = tbl_rd.last_heard;
    sub_b = old_lh;
    eq_a  = tbl_rd.source;
    eq_b  = id_q;
    unique case (state)
      ST_DIFF: begin
        sub_a = now_q;
        sub_b = tbl_rd.last_heard;
      end
      ST_CHK: begin
        sub_a = diff_q;
        sub_b = {{(TIME_W-SIL_W){1'b0}}, cfg.silent_time};
        eq_a  = cfg.pinned_source;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_next       = state;
    scan_idx_next    = scan_idx;
    free_found_next  = free_found;
    free_i_next      = free_i;
    old_found_next   = old_found;
    old_i_next       = old_i;
    old_lh_next      = old_lh;
    pick_ok_next     = pick_ok;
    pick_next        = pick;
    fresh_next       = fresh;
    diff_q_next      = diff_q;
    act_idle_next    = act_idle;
    used_next        = used;
    have_active_next = have_active;
    cur_next         = cur;
    res_next         = res_q;
    tbl_wr           = '0;
    tbl_rd_addr      = cur;
    want_set         = 1'b0;
    want_v           = 1'b0;
    want_idx         = '0;
    avail            = 1'b0;
    changed          = 1'b0;

    unique case (state)
      ST_IDLE: begin
        tbl_rd_addr = '0;
        if (pkt_valid) begin
          scan_idx_next   = '0;
          free_found_next = 1'b0;
          old_found_next  = 1'b0;
          state_next      = ST_SCAN;
        end
      end

      ST_SCAN: begin
        if (used[scan_idx] && alu_eq) begin
          pick_ok_next = 1'b1;
          pick_next    = scan_idx;
          fresh_next   = 1'b0;
          state_next   = ST_DIFF;
        end else begin
          if (!used[scan_idx] && !free_found) begin
            free_found_next = 1'b1;
            free_i_next     = scan_idx;
          end
          // the active slot is never evicted; ties keep the lower index
          if (used[scan_idx] && !(have_active && scan_idx == cur) &&
              (!old_found || alu_lt)) begin
            old_found_next = 1'b1;
            old_i_next     = scan_idx;
            old_lh_next    = tbl_rd.last_heard;
          end
          if (scan_idx == LAST_SLOT) begin
            fresh_next   = 1'b1;
            pick_ok_next = free_found_next || old_found_next;
            pick_next    = free_found_next ? free_i_next : old_i_next;
            state_next   = ST_DIFF;
          end else begin
            scan_idx_next = scan_idx + slot_idx_t'(1);
            tbl_rd_addr   = scan_idx + slot_idx_t'(1);
          end
        end
      end

      ST_DIFF: begin
        // read data now holds the active slot's entry
        diff_q_next   = alu_diff;
        act_idle_next = tbl_rd.idle;
        if (pick_ok) begin
          tbl_wr.en         = 1'b1;
          tbl_wr.src_en     = fresh;
          tbl_wr.addr       = pick;
          tbl_wr.source     = id_q;
          tbl_wr.last_heard = now_q;
          tbl_wr.idle       = idle_q;
          if (fresh) begin
            used_next[pick] = 1'b1;
          end
        end
        state_next = ST_CHK;
      end

      ST_CHK: begin
        avail = used[cur] && alu_lt;
        if (pick_ok) begin
          if (cfg.pinned_source != '0) begin
            if (alu_eq) begin
              want_set = 1'b1;
              want_v   = 1'b1;
              want_idx = pick;
            end else if (have_active && cur == pick) begin
              want_set = 1'b1;
            end
          end else if (!(have_active && cur == pick)) begin
            if (!have_active || !avail || (act_idle && !idle_q)) begin
              want_set = 1'b1;
              want_v   = 1'b1;
              want_idx = pick;
            end
          end
          if (want_set && !(want_v == have_active && (!want_v || want_idx == cur))) begin
            changed          = 1'b1;
            have_active_next = want_v;
            cur_next         = want_v ? want_idx : '0;
          end
          res_next.accepted      = 1'b1;
          res_next.slot          = OUT_SLOT_W'(pick);
          res_next.new_entry     = fresh;
          res_next.source_active = have_active_next && (cur_next == pick);
        end else begin
          res_next.accepted      = 1'b0;
          res_next.slot          = '0;
          res_next.new_entry     = 1'b0;
          res_next.source_active = 1'b0;
        end
        res_next.active_valid = have_active_next;
        res_next.active_slot  = have_active_next ? OUT_SLOT_W'(cur_next) : '0;
        res_next.switched     = changed;
        state_next            = ST_OUT;
      end

      ST_OUT: begin
        if (res_ready) begin
          state_next = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      used        <= '0;
      have_active <= 1'b0;
      cur         <= '0;
    end else begin
      state       <= state_next;
      used        <= used_next;
      have_active <= have_active_next;
      cur         <= cur_next;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && pkt_valid) begin
      id_q   <= pkt_data.source_id;
      now_q  <= pkt_data.now_ms;
      idle_q <= pkt_data.idle;
    end
    scan_idx   <= scan_idx_next;
    free_found <= free_found_next;
    free_i     <= free_i_next;
    old_found  <= old_found_next;
    old_i      <= old_i_next;
    old_lh     <= old_lh_next;
    pick_ok    <= pick_ok_next;
    pick       <= pick_next;
    fresh      <= fresh_next;
    diff_q     <= diff_q_next;
    act_idle   <= act_idle_next;
    res_q      <= res_next;
  end

endmodule

@@ hw/rtl/source_slot_table_failover_arbiter.sv @@
// top level of the source slot table failover arbiter
//
//   channel  dir  handshake              word
//   pkt      in   pkt.valid/pkt.ready    source_id, now_ms, idle
//   res      out  res.valid/res.ready    accepted .. switched
//   cfg      in   cfg_we                 cfg_index, cfg_data
//
// a new word is taken only after the last result is taken, and the scan ends
// early on a hit: one slot per cycle is scanned through the single table read
// port, then the DIFF and CHK states use the shared subtract unit for the
// silence check before the result is shown in the OUT state.
// pkt.ready is high only when idle; a result held by res.ready stalls the block.
// synchronous reset clears the used bits and active slot, resets the config.
module source_slot_table_failover_arbiter (
  input  logic                             clk,
  input  logic                             rst,
  ssfa_pkt_if.sink                         pkt,
  ssfa_res_if.source                       res,
  input  logic                             cfg_we,
  input  logic [ssfa_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ssfa_pkg::CFG_W-1:0]       cfg_data
);
  import ssfa_pkg::*;
`include "source_slot_table_failover_arbiter_macros.svh"

  cfg_t      cfg;
  tbl_wr_t   tbl_wr;
  tbl_rd_t   tbl_rd;
  slot_idx_t tbl_rd_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pinned_source <= '0;
      cfg.silent_time   <= SILENT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_PINNED_SOURCE: cfg.pinned_source <= cfg_data[ID_W-1:0];
        REG_SILENT_TIME:   cfg.silent_time   <= cfg_data[SIL_W-1:0];
        default: begin
        end
      endcase
    end
  end

  ssfa_table u_table (
    .clk     (clk),
    .wr      (tbl_wr),
    .rd_addr (tbl_rd_addr),
    .rd_data (tbl_rd)
  );

  ssfa_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .pkt_valid   (pkt.valid),
    .pkt_ready   (pkt.ready),
    .pkt_data    (pkt.data),
    .res_valid   (res.valid),
    .res_ready   (res.ready),
    .res_data    (res.data),
    .tbl_wr      (tbl_wr),
    .tbl_rd_addr (tbl_rd_addr),
    .tbl_rd      (tbl_rd)
  );

  // never take a word while a result is pending
  `SSFA_ASSERT_IMP(a_ready_excl, clk, rst, pkt.ready, !res.valid)
  // busy right after a word is taken
  `SSFA_ASSERT_NXT(a_busy_after_accept, clk, rst, pkt.valid && pkt.ready, !pkt.ready)
  // an active source is the active slot
  `SSFA_ASSERT_IMP(a_active_consistent, clk, rst, res.valid && res.data.source_active,
    res.data.active_valid && res.data.active_slot == res.data.slot)
  // no active slot reads as slot zero
  `SSFA_ASSERT_IMP(a_no_active_zero, clk, rst, res.valid && !res.data.active_valid,
    res.data.active_slot == '0 && !res.data.source_active)

endmodule

@@ tb/ssfa_arbiter_checker.sv @@
// checker for the failover arbiter: predicts each result word and compares it
module ssfa_arbiter_checker (
  input  logic                           clk,
  input  logic                           rst,
  ssfa_pkt_if                            pkt,
  ssfa_res_if                            res,
  input  logic                           cfg_we,
  input  logic [ssfa_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ssfa_pkg::CFG_W-1:0]     cfg_data,
  output int                             mismatches,
  output int                             outstanding
);
  timeunit 1ns;
  timeprecision 1ps;
  import ssfa_pkg::*;

  logic [SLOTS-1:0]  used;
  logic [ID_W-1:0]   owner [SLOTS];
  logic [TIME_W-1:0] heard [SLOTS];
  logic              resting [SLOTS];
  logic              have_drv;
  slot_idx_t         drv_slot;
  logic [ID_W-1:0]   pin_id;
  logic [SIL_W-1:0]  gone_after;
  res_t              want_q[$];

  function automatic string show(res_t r);
    return $sformatf("acc=%0b slot=%0d new=%0b act=%0b av=%0b as=%0d sw=%0b",
                     r.accepted, r.slot, r.new_entry, r.source_active,
                     r.active_valid, r.active_slot, r.switched);
  endfunction

  // table lookup, allocation and takeover decision for one packet word
  function automatic res_t arbitrate(pkt_t p);
    int                hit;
    int                vacant;
    int                oldest;
    int                pick;
    int                i;
    logic              fresh;
    logic              changed;
    logic              avail;
    logic              next_valid;
    slot_idx_t         next_slot;
    logic [TIME_W-1:0] quiet;
    res_t              r;
    hit    = -1;
    vacant = -1;
    oldest = -1;
    r      = '0;
    for (i = 0; i < SLOTS && hit < 0; i++) begin
      if (used[i] && owner[i] == p.source_id) begin
        hit = i;
      end else begin
        if (!used[i] && vacant < 0) vacant = i;
        // oldest entry that is not driving, lowest index on a tie
        if (used[i] && !(have_drv && drv_slot == i) &&
            (oldest < 0 || heard[i] < heard[oldest])) oldest = i;
      end
    end
    fresh = (hit < 0);
    pick  = fresh ? ((vacant >= 0) ? vacant : oldest) : hit;
    if (pick < 0) begin
      r.active_valid = have_drv;
      r.active_slot  = have_drv ? drv_slot : '0;
      return r;
    end
    if (fresh) begin
      used[pick]  = 1'b1;
      owner[pick] = p.source_id;
    end
    heard[pick]   = p.now_ms;
    resting[pick] = p.idle;
    next_valid = have_drv;
    next_slot  = drv_slot;
    if (pin_id != '0) begin
      if (p.source_id == pin_id) begin
        next_valid = 1'b1;
        next_slot  = slot_idx_t'(pick);
      end else if (have_drv && drv_slot == pick) begin
        next_valid = 1'b0;
        next_slot  = '0;
      end
    end else if (!(have_drv && drv_slot == pick)) begin
      // silence wraps modulo 2^32
      quiet = p.now_ms - heard[drv_slot];
      avail = have_drv && used[drv_slot] && (quiet < gone_after);
      if (!avail || (resting[drv_slot] && !p.idle)) begin
        next_valid = 1'b1;
        next_slot  = slot_idx_t'(pick);
      end
    end
    changed  = (next_valid != have_drv) || (next_valid && next_slot != drv_slot);
    have_drv = next_valid;
    drv_slot = next_valid ? next_slot : '0;
    r.accepted      = 1'b1;
    r.slot          = pick[OUT_SLOT_W-1:0];
    r.new_entry     = fresh;
    r.source_active = have_drv && drv_slot == pick;
    r.active_valid  = have_drv;
    r.active_slot   = drv_slot;
    r.switched      = changed;
    return r;
  endfunction

  always @(posedge clk) begin
    res_t got;
    res_t want;
    if (rst) begin
      used       = '0;
      have_drv   = 1'b0;
      drv_slot   = '0;
      pin_id     = '0;
      gone_after = SILENT_RESET;
      mismatches = 0;
      want_q.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_PINNED_SOURCE) pin_id = cfg_data[ID_W-1:0];
        else if (cfg_index == REG_SILENT_TIME) gone_after = cfg_data[SIL_W-1:0];
      end
      if (pkt.valid && pkt.ready) want_q.push_back(arbitrate(pkt.data));
      if (res.valid && res.ready) begin
        got = res.data;
        if (want_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result word: %s", show(got));
        end else begin
          want = want_q.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("result mismatch: expected %s, got %s", show(want), show(got));
          end
        end
      end
    end
    outstanding = want_q.size();
  end

endmodule

@@ tb/testbench.sv @@
// bench top: clock, reset, packet stimulus in phases, receiver stalls and the verdict
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import ssfa_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;
  localparam int PHASE_WORDS = 105;
  localparam int HOLD_CYCLES = 300;

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;
  int                   mismatches;
  int                   outstanding;
  int                   tx_idle_pct;
  int                   rx_stall_pct;
  int                   hold_left;
  logic [TIME_W-1:0]    clock_ms;
  logic [SIL_W-1:0]     quiet_ms;
  logic [ID_W-1:0]      pool [6];

  ssfa_pkt_if pkt_ch();
  ssfa_res_if res_ch();

  source_slot_table_failover_arbiter DUT (
    .clk       (clk),
    .rst       (rst),
    .pkt       (pkt_ch),
    .res       (res_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  ssfa_arbiter_checker watch (
    .clk         (clk),
    .rst         (rst),
    .pkt         (pkt_ch),
    .res         (res_ch),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // receiver: long hold-off when asked, random stalls otherwise
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      res_ch.ready <= 1'b0;
    end else begin
      res_ch.ready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  function automatic pkt_t word(logic [ID_W-1:0] id, logic [TIME_W-1:0] now, logic idle);
    pkt_t w;
    w.source_id = id;
    w.now_ms    = now;
    w.idle      = idle;
    return w;
  endfunction

  // mostly a small set of sources on an advancing clock, some noise
  function automatic pkt_t random_word();
    int               roll;
    logic [ID_W-1:0]  id;
    roll = $urandom_range(99);
    id   = (roll < 85) ? pool[$urandom_range(5)] : $urandom;
    roll = $urandom_range(99);
    if (roll < 10) begin
      // same time as before: ties on eviction
    end else if (roll < 65) begin
      clock_ms += $urandom_range(300, 1);
    end else if (roll < 80) begin
      // right around the silence limit
      clock_ms += quiet_ms + $urandom_range(2) - 1;
    end else if (roll < 95) begin
      clock_ms += $urandom_range(70000);
    end else begin
      clock_ms = $urandom;
    end
    return word(id, clock_ms, 1'($urandom_range(1)));
  endfunction

  task automatic send_word(pkt_t w);
    while ($urandom_range(99) < tx_idle_pct) begin
      pkt_ch.valid <= 1'b0;
      @(negedge clk);
    end
    pkt_ch.valid <= 1'b1;
    pkt_ch.data  <= w;
    do @(posedge clk); while (!pkt_ch.ready);
    @(negedge clk);
  endtask

  task automatic drain();
    pkt_ch.valid <= 1'b0;
    wait (outstanding == 0);
    @(negedge clk);
  endtask

  // one write, then cfg_we is dropped again so back to back writes never collide
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
    cfg_we    <= 1'b0;
    @(negedge clk);
  endtask

  task automatic refill_pool();
    int i;
    pool[0] = '0;
    pool[1] = '1;
    for (i = 2; i < 6; i++) pool[i] = $urandom;
  endtask

  task automatic run_phase(logic [ID_W-1:0] pinned, logic [CFG_W-1:0] silent, int tx_pct,
                           int rx_pct, logic hold, logic pause_mid, logic spare);
    int n;
    drain();
    if (spare) begin
      write_reg(REG_SPARE_2, $urandom);
      write_reg(REG_SPARE_3, $urandom);
    end
    write_reg(REG_PINNED_SOURCE, pinned);
    write_reg(REG_SILENT_TIME, silent);
    quiet_ms     = silent[SIL_W-1:0];
    tx_idle_pct  = tx_pct;
    rx_stall_pct = rx_pct;
    if (hold) hold_left = HOLD_CYCLES;
    for (n = 0; n < PHASE_WORDS; n++) begin
      if (pause_mid && n == PHASE_WORDS / 2) drain();
      send_word(random_word());
    end
  endtask

  initial begin
    rst           = 1'b1;
    cfg_we        = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    pkt_ch.valid  = 1'b0;
    pkt_ch.data   = '0;
    res_ch.ready  = 1'b0;
    hold_left     = 0;
    tx_idle_pct   = 0;
    rx_stall_pct  = 0;
    clock_ms      = '0;
    quiet_ms      = SILENT_RESET;
    repeat (5) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed words under reset settings
    send_word(word('0, '0, 1'b0));
    send_word(word('1, 32'd10, 1'b1));
    send_word(word('0, 32'd20, 1'b1));
    // idle driver loses to a moving source
    send_word(word('1, 32'd30, 1'b0));
    send_word(word(32'd3, 32'd30, 1'b0));
    send_word(word(32'd4, 32'd20, 1'b1));
    // full table: evict the oldest non-driving entry, lowest index on a tie
    send_word(word(32'd5, 32'd40, 1'b0));
    send_word(word(32'd6, 32'd2000, 1'b0));
    send_word(word(32'd5, 32'hFFFF_FF00, 1'b1));
    send_word(word(32'd6, 32'd16, 1'b0));
    send_word(word(32'd3, '1, 1'b0));
    send_word(word(32'd7, 32'd1015, 1'b0));
    drain();
    // pinned mode: a non-pinned driver is dropped, the pinned one takes over
    write_reg(REG_PINNED_SOURCE, 32'd5);
    send_word(word(32'd7, 32'd1016, 1'b0));
    send_word(word(32'd6, 32'd1017, 1'b0));
    send_word(word(32'd5, 32'd1018, 1'b1));
    send_word(word(32'd3, 32'd9000, 1'b0));
    drain();
    // leaving pinned mode keeps the driver until a packet decides
    write_reg(REG_PINNED_SOURCE, '0);
    send_word(word(32'd6, 32'd1020, 1'b0));
    send_word(word(32'd5, 32'd1021, 1'b1));
    drain();
    // zero silence limit: the driver always counts as gone
    write_reg(REG_SILENT_TIME, '0);
    send_word(word(32'd3, 32'd1022, 1'b1));
    send_word(word(32'd6, 32'd1022, 1'b1));
    send_word(word(32'd3, 32'd1022, 1'b0));

    refill_pool();
    run_phase('0, 32'd1000, 0, 0, 1'b0, 1'b0, 1'b0);
    run_phase('0, 32'd1, 87, 0, 1'b0, 1'b0, 1'b0);
    refill_pool();
    run_phase('0, 32'd65535, 0, 87, 1'b0, 1'b1, 1'b0);
    run_phase(pool[2], 32'd400, 21, 21, 1'b0, 1'b0, 1'b0);
    run_phase('1, 32'd200, 0, 0, 1'b1, 1'b0, 1'b0);
    refill_pool();
    run_phase('0, 32'd0, 87, 0, 1'b0, 1'b0, 1'b0);
    run_phase('0, 32'd300, 0, 87, 1'b0, 1'b0, 1'b1);
    refill_pool();
    run_phase($urandom | 32'h1, 32'd700, 21, 21, 1'b0, 1'b0, 1'b0);
    clock_ms = 32'hFFFF_F000;
    // upper bits of the silence write are dropped
    run_phase('0, 32'h0001_2345, 0, 0, 1'b0, 1'b0, 1'b0);

    drain();
    repeat (20) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
